@@ hdl/msr_pkg.sv @@
package msr_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenOutW = 7;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0] BeginMarkerRst  = 8'd0;
  localparam logic [ByteW-1:0] MiddleMarkerRst = 8'd1;
  localparam logic [ByteW-1:0] EndMarkerRst    = 8'd2;

  typedef enum logic [1:0] {
    HDR_INVALID = 2'd0,
    HDR_BEGIN   = 2'd1,
    HDR_MIDDLE  = 2'd2,
    HDR_END     = 2'd3
  } hdr_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BEGIN_MARKER  = 2'd0,
    CFG_MIDDLE_MARKER = 2'd1,
    CFG_END_MARKER    = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    KIND_BYTE    = 1'b0,
    KIND_DISCARD = 1'b1
  } kind_e;

  typedef enum logic {
    ST_RECV = 1'b0,
    ST_DUMP = 1'b1
  } state_e;

endpackage

@@ hdl/msr_if.sv @@
interface msr_in_if;
  logic                      valid;
  logic                      ready;
  logic [msr_pkg::ByteW-1:0] rx_byte;
  logic                      write_done;

  modport source (output valid, rx_byte, write_done, input ready);
  modport sink   (input valid, rx_byte, write_done, output ready);
endinterface

interface msr_out_if;
  logic                        valid;
  logic                        ready;
  logic                        result_kind;
  logic [msr_pkg::ByteW-1:0]   msg_byte;
  logic                        msg_last;
  logic [msr_pkg::LenOutW-1:0] msg_length;

  modport source (output valid, result_kind, msg_byte, msg_last, msg_length, input ready);
  modport sink   (input valid, result_kind, msg_byte, msg_last, msg_length, output ready);
endinterface

interface msr_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [msr_pkg::CfgIdxW-1:0] index;
  logic [msr_pkg::ByteW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ hdl/msr_store.sv @@
module msr_store #(
  parameter int unsigned Depth = 64
) (
  input  logic                             clk_i,
  input  logic                             wr_en_i,
  input  logic [$clog2(Depth)-1:0]         wr_addr_i,
  input  logic [msr_pkg::ByteW-1:0]        wr_data_i,
  input  logic                             rd_en_i,
  input  logic [$clog2(Depth)-1:0]         rd_addr_i,
  output logic [msr_pkg::ByteW-1:0]        rd_data_o
);

  logic [msr_pkg::ByteW-1:0] mem [Depth];
  logic [msr_pkg::ByteW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hdl/marker_segment_reassembler_core.sv @@
// Channel   Dir  Handshake      Payload
// in_ch     in   valid/ready    rx_byte[7:0], write_done
// out_ch    out  valid/ready    result_kind, msg_byte[7:0], msg_last, msg_length[6:0]
// cfg_ch    in   valid/ready    index[1:0], data[7:0]
//
// Received bytes: one per cycle while reassembling; payload bytes of a valid
// write go straight into the message store while it has room.
// Dump: each result goes through a store read, then the output register; no new read
// issues until the last lands. Overflow: one discard. Input is held off for the whole dump.
// Reset: asynchronous, active low; markers return to 0/1/2, message cleared.
// Stalls: out_ch.ready low freezes the dump; cfg_ch is always ready.
module marker_segment_reassembler_core #(
  parameter int unsigned MAX_MESSAGE = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  msr_in_if.sink   in_ch,
  msr_cfg_if.sink  cfg_ch,
  msr_out_if.source out_ch
);

  localparam int unsigned AddrW = $clog2(MAX_MESSAGE);
  localparam int unsigned LenW  = $clog2(MAX_MESSAGE + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_MESSAGE);

  // ---------------------------------------------------------------------------
  // Marker registers
  // ---------------------------------------------------------------------------
  logic [msr_pkg::ByteW-1:0] begin_marker_q, middle_marker_q, end_marker_q;
  logic                      cfg_fire;

  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_marker_q  <= msr_pkg::BeginMarkerRst;
      middle_marker_q <= msr_pkg::MiddleMarkerRst;
      end_marker_q    <= msr_pkg::EndMarkerRst;
    end else if (cfg_fire) begin
      case (cfg_ch.index)
        msr_pkg::CFG_BEGIN_MARKER:  begin_marker_q  <= cfg_ch.data;
        msr_pkg::CFG_MIDDLE_MARKER: middle_marker_q <= cfg_ch.data;
        msr_pkg::CFG_END_MARKER:    end_marker_q    <= cfg_ch.data;
        default: ;  // index beyond the register list: drop the write
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Reassembly state
  // ---------------------------------------------------------------------------
  msr_pkg::state_e state_q, state_d;
  msr_pkg::hdr_e   header_q, header_d;
  logic            at_start_q, at_start_d;
  logic [LenW-1:0] count_q, count_d;
  logic            ovf_q, ovf_d;

  // dump bookkeeping
  logic            discard_q, discard_d;
  logic [LenW-1:0] dump_len_q, dump_len_d;
  logic [LenW-1:0] dump_idx_q, dump_idx_d;
  logic            rd_pend_q, pend_last_q;

  // output register
  logic                      out_valid_q;
  logic                      out_kind_q;
  logic [msr_pkg::ByteW-1:0] out_byte_q;
  logic                      out_last_q;
  logic [LenW-1:0]           out_len_q;

  logic                      in_fire;
  logic                      out_free;
  logic                      start_dump;
  logic                      store_ok;
  logic                      is_begin, is_mid, is_end;
  logic                      wr_en;
  logic                      rd_issue;
  logic                      load_discard;
  logic                      load_data;
  logic                      issue_left;
  logic [LenW-1:0]           idx_inc;
  logic [msr_pkg::ByteW-1:0] rd_data;

  assign in_fire    = in_ch.valid && in_ch.ready;
  assign out_free   = !out_valid_q || out_ch.ready;
  assign store_ok   = count_q < MaxLen;
  assign is_begin   = in_ch.rx_byte == begin_marker_q;
  assign is_mid     = in_ch.rx_byte == middle_marker_q;
  assign is_end     = in_ch.rx_byte == end_marker_q;
  assign issue_left = dump_idx_q != dump_len_q;
  assign idx_inc    = LenW'(dump_idx_q + 1'b1);

  // last payload byte of an end write starts the dump
  assign start_dump = in_fire && !at_start_q && (header_q == msr_pkg::HDR_END)
                      && in_ch.write_done;
  // payload byte of a valid write goes into the store while there is room
  assign wr_en      = in_fire && !at_start_q && (header_q != msr_pkg::HDR_INVALID)
                      && store_ok;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      msr_pkg::ST_RECV: begin
        if (start_dump) begin
          state_d = msr_pkg::ST_DUMP;
        end
      end
      msr_pkg::ST_DUMP: begin
        if ((discard_q && out_free) || (rd_pend_q && pend_last_q)) begin
          state_d = msr_pkg::ST_RECV;
        end
      end
      default: state_d = msr_pkg::ST_RECV;
    endcase
  end

  // state machine outputs
  always_comb begin
    in_ch.ready  = 1'b0;
    rd_issue     = 1'b0;
    load_discard = 1'b0;
    load_data    = 1'b0;
    unique case (state_q)
      msr_pkg::ST_RECV: begin
        in_ch.ready = 1'b1;
      end
      msr_pkg::ST_DUMP: begin
        load_discard = discard_q && out_free;
        // issue a read only when the output register will be free when it lands
        rd_issue     = !discard_q && !rd_pend_q && issue_left && out_free;
        load_data    = rd_pend_q;
      end
      default: ;
    endcase
  end

  // message bookkeeping
  always_comb begin
    header_d   = header_q;
    at_start_d = at_start_q;
    count_d    = count_q;
    ovf_d      = ovf_q;
    discard_d  = discard_q;
    dump_len_d = dump_len_q;
    dump_idx_d = dump_idx_q;
    if (in_fire) begin
      if (at_start_q) begin
        if (in_ch.write_done || !(is_begin || is_mid || is_end)) begin
          // too short or unknown marker: drop the partial message
          count_d  = '0;
          ovf_d    = 1'b0;
          header_d = msr_pkg::HDR_INVALID;
        end else begin
          if (is_begin) begin
            count_d = '0;
            ovf_d   = 1'b0;
          end
          priority if (is_end) begin
            header_d = msr_pkg::HDR_END;
          end else if (is_begin) begin
            header_d = msr_pkg::HDR_BEGIN;
          end else begin
            header_d = msr_pkg::HDR_MIDDLE;
          end
        end
        at_start_d = in_ch.write_done;
      end else begin
        if (header_q != msr_pkg::HDR_INVALID) begin
          if (store_ok) begin
            count_d = LenW'(count_q + 1'b1);
          end else begin
            ovf_d = 1'b1;
          end
        end
        if (start_dump) begin
          discard_d  = ovf_q || !store_ok;
          dump_len_d = LenW'(count_q + 1'b1);
          dump_idx_d = '0;
          count_d    = '0;
          ovf_d      = 1'b0;
        end
        if (in_ch.write_done) begin
          at_start_d = 1'b1;
          header_d   = msr_pkg::HDR_INVALID;
        end
      end
    end
    if (rd_issue) begin
      dump_idx_d = idx_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= msr_pkg::ST_RECV;
      header_q    <= msr_pkg::HDR_INVALID;
      at_start_q  <= 1'b1;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      discard_q   <= 1'b0;
      dump_len_q  <= '0;
      dump_idx_q  <= '0;
      rd_pend_q   <= 1'b0;
      pend_last_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      header_q   <= header_d;
      at_start_q <= at_start_d;
      count_q    <= count_d;
      ovf_q      <= ovf_d;
      discard_q  <= discard_d;
      dump_len_q <= dump_len_d;
      dump_idx_q <= dump_idx_d;
      rd_pend_q  <= rd_issue;
      if (rd_issue) begin
        pend_last_q <= idx_inc == dump_len_q;
      end
      if (load_discard || load_data) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // output payload: no reset needed
  always_ff @(posedge clk_i) begin
    if (load_discard) begin
      out_kind_q <= msr_pkg::KIND_DISCARD;
      out_byte_q <= '0;
      out_last_q <= 1'b1;
      out_len_q  <= '0;
    end else if (load_data) begin
      out_kind_q <= msr_pkg::KIND_BYTE;
      out_byte_q <= rd_data;
      out_last_q <= pend_last_q;
      out_len_q  <= dump_len_q;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.result_kind = out_kind_q;
  assign out_ch.msg_byte    = out_byte_q;
  assign out_ch.msg_last    = out_last_q;
  assign out_ch.msg_length  = msr_pkg::LenOutW'(out_len_q);

  // ---------------------------------------------------------------------------
  // Message store. Writes happen only while receiving and reads only while
  // dumping, so the two ports never touch the same entry in one cycle.
  // ---------------------------------------------------------------------------
  msr_store #(
    .Depth(MAX_MESSAGE)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (count_q[AddrW-1:0]),
    .wr_data_i (in_ch.rx_byte),
    .rd_en_i   (rd_issue),
    .rd_addr_i (dump_idx_q[AddrW-1:0]),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxLen)
    else $error("message count beyond store depth");

  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (count_q == MaxLen))
    else $error("overflow flagged with room left in the store");

  a_land_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_pend_q |-> !out_valid_q)
    else $error("store read landed on an occupied output register");

  a_dump_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::ST_RECV && state_d == msr_pkg::ST_DUMP) |->
      (in_fire && !at_start_q))
    else $error("dump started without a payload byte");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == msr_pkg::ST_DUMP) |-> (dump_idx_q <= dump_len_q))
    else $error("dump index ran past the message length");

endmodule

@@ bench/msr_reassembly_checker.sv @@
`timescale 1ns / 1ps

module msr_reassembly_checker
  import msr_pkg::*;
#(
  parameter int unsigned MaxMessage = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  msr_in_if           in_ch,
  msr_cfg_if          cfg_ch,
  msr_out_if          out_ch,
  output int unsigned err_count_o,
  output int unsigned pending_o
);

  typedef struct packed {
    kind_e              kind;
    logic [ByteW-1:0]   data;
    logic               last;
    logic [LenOutW-1:0] len;
  } msg_result_t;

  logic [ByteW-1:0] begin_mk;
  logic [ByteW-1:0] middle_mk;
  logic [ByteW-1:0] end_mk;
  logic [ByteW-1:0] msg_store [MaxMessage];
  int unsigned      msg_count;
  bit               overflowed;
  bit               at_write_start;
  hdr_e             write_hdr;

  msg_result_t awaited_results [$];
  msg_result_t want;
  int unsigned errors;

  task automatic clear_message();
    msg_count  = 0;
    overflowed = 1'b0;
  endtask

  // Queue either the whole message or one discard, then clear.
  task automatic dump_message();
    if (overflowed) begin
      awaited_results.push_back('{kind: KIND_DISCARD, data: '0, last: 1'b1, len: '0});
    end else begin
      for (int unsigned i = 0; i < msg_count; i++) begin
        awaited_results.push_back('{kind: KIND_BYTE, data: msg_store[i],
                                    last: (i + 1 == msg_count),
                                    len: LenOutW'(msg_count)});
      end
    end
    clear_message();
  endtask

  task automatic reassemble_byte(input logic [ByteW-1:0] b, input logic done);
    logic is_begin;
    logic is_middle;
    logic is_end;
    is_begin  = (b == begin_mk);
    is_middle = (b == middle_mk);
    is_end    = (b == end_mk);
    if (at_write_start) begin
      if (done || !(is_begin || is_middle || is_end)) begin
        clear_message();
        write_hdr = HDR_INVALID;
      end else begin
        if (is_begin) clear_message();
        if (is_end) write_hdr = HDR_END;
        else if (is_begin) write_hdr = HDR_BEGIN;
        else write_hdr = HDR_MIDDLE;
      end
      at_write_start = done;
    end else begin
      if (write_hdr != HDR_INVALID) begin
        if (msg_count < MaxMessage) begin
          msg_store[msg_count] = b;
          msg_count++;
        end else begin
          overflowed = 1'b1;
        end
        if (done && write_hdr == HDR_END) dump_message();
      end
      if (done) begin
        at_write_start = 1'b1;
        write_hdr      = HDR_INVALID;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      begin_mk       = BeginMarkerRst;
      middle_mk      = MiddleMarkerRst;
      end_mk         = EndMarkerRst;
      msg_count      = 0;
      overflowed     = 1'b0;
      at_write_start = 1'b1;
      write_hdr      = HDR_INVALID;
      errors         = 0;
      awaited_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_BEGIN_MARKER:  begin_mk  = cfg_ch.data;
          CFG_MIDDLE_MARKER: middle_mk = cfg_ch.data;
          CFG_END_MARKER:    end_mk    = cfg_ch.data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) reassemble_byte(in_ch.rx_byte, in_ch.write_done);
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result kind=%0d byte=%02h last=%0d length=%0d", $time,
                   out_ch.result_kind, out_ch.msg_byte, out_ch.msg_last, out_ch.msg_length);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          if (out_ch.result_kind !== want.kind || out_ch.msg_byte !== want.data ||
              out_ch.msg_last !== want.last || out_ch.msg_length !== want.len) begin
            $display("%0t: expected kind=%0d byte=%02h last=%0d length=%0d", $time,
                     want.kind, want.data, want.last, want.len);
            $display("%0t:   actual kind=%0d byte=%02h last=%0d length=%0d", $time,
                     out_ch.result_kind, out_ch.msg_byte, out_ch.msg_last, out_ch.msg_length);
            errors++;
          end
        end
      end
    end
    err_count_o <= errors;
    pending_o   <= awaited_results.size();
  end

endmodule

@@ bench/tb_marker_segment_reassembler_core.sv @@
`timescale 1ns / 1ps

module tb_marker_segment_reassembler_core;
  import msr_pkg::*;

  localparam int unsigned MaxMessage    = 64;
  localparam int unsigned IdlePercent   = 32;
  // Cycles to let the block finish storing after the last result, before a
  // marker write.
  localparam int unsigned SettleCycles  = 8;
  localparam int unsigned TailCycles    = 20;
  // Cycles without any transaction on any channel before giving up.
  localparam int unsigned WatchdogLimit = 2000;

  // Directed opening under the reset markers (begin 0, middle 1, end 2).
  // Each entry is {write_done, rx_byte}.
  localparam logic [8:0] DirectedSeq [26] = '{
    // one-byte write carrying the begin marker: clear, emit nothing
    {1'b1, 8'h00},
    // unknown marker: clear and ignore the rest of the write
    {1'b0, 8'h77}, {1'b0, 8'hFF}, {1'b1, 8'h00},
    // begin, middle, end with payload at both byte extremes
    {1'b0, 8'h00}, {1'b0, 8'h00}, {1'b1, 8'hFF},
    {1'b0, 8'h01}, {1'b1, 8'hAA},
    {1'b0, 8'h02}, {1'b1, 8'h55},
    // middle and end with no begin still emit
    {1'b0, 8'h01}, {1'b1, 8'h01},
    {1'b0, 8'h02}, {1'b1, 8'h80},
    // an unknown write between begin and end drops the begin payload
    {1'b0, 8'h00}, {1'b1, 8'h11},
    {1'b0, 8'h09}, {1'b1, 8'h22},
    {1'b0, 8'h02}, {1'b1, 8'h33},
    // a one-byte write between begin and end drops the begin payload
    {1'b0, 8'h00}, {1'b1, 8'h44},
    {1'b1, 8'h01},
    {1'b0, 8'h02}, {1'b1, 8'h66}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  msr_in_if  in_ch  ();
  msr_cfg_if cfg_ch ();
  msr_out_if out_ch ();

  // Marker values currently programmed, used to build well-formed writes.
  logic [ByteW-1:0] mk_begin;
  logic [ByteW-1:0] mk_middle;
  logic [ByteW-1:0] mk_end;

  bit          no_idle = 1'b0;
  int unsigned items_sent = 0;
  int unsigned idle_cycles = 0;
  int unsigned err_count;
  int unsigned pending;

  always #2 clk_i = ~clk_i;

  marker_segment_reassembler_core #(
    .MAX_MESSAGE(MaxMessage)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_ch (cfg_ch),
    .out_ch (out_ch)
  );

  msr_reassembly_checker #(
    .MaxMessage(MaxMessage)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ch       (in_ch),
    .cfg_ch      (cfg_ch),
    .out_ch      (out_ch),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  // Stall the result side at random, except through the no-idle stretch.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_ch.ready <= no_idle || ($urandom_range(99) >= IdlePercent);
    end
  end

  // Watchdog: end the run once no channel has moved for too long.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one byte, idling first at random, and hold it until the transaction
  // completes. Valid is left high so that back-to-back bytes need no gap.
  task automatic send_byte(input logic [ByteW-1:0] b, input logic done);
    while (!no_idle && $urandom_range(99) < IdlePercent) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid      <= 1'b1;
    in_ch.rx_byte    <= b;
    in_ch.write_done <= done;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  // One link write: header byte, then random payload; zero payload makes it a
  // one-byte write.
  task automatic send_write(input logic [ByteW-1:0] hdr, input int unsigned n_payload);
    send_byte(hdr, n_payload == 0);
    for (int unsigned i = 1; i <= n_payload; i++) begin
      send_byte(ByteW'($urandom_range(255)), i == n_payload);
    end
  endtask

  // A well-formed message: begin, (n_seg - 2) middles, end.
  task automatic send_message(input int unsigned n_seg, input int unsigned seg_max);
    send_write(mk_begin, $urandom_range(seg_max, 1));
    for (int unsigned i = 2; i < n_seg; i++) send_write(mk_middle, $urandom_range(seg_max, 1));
    send_write(mk_end, $urandom_range(seg_max, 1));
  endtask

  // Hold the sender off until every predicted result has arrived.
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // Present one register write; valid stays high for the next one.
  task automatic write_marker(input cfg_idx_e idx, input logic [ByteW-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
  endtask

  // Reprogram all markers once the block has gone quiet.
  task automatic change_markers(input logic [ByteW-1:0] b, input logic [ByteW-1:0] m,
                                input logic [ByteW-1:0] e);
    drain_results();
    repeat (SettleCycles) @(posedge clk_i);
    write_marker(CFG_BEGIN_MARKER, b);
    write_marker(CFG_MIDDLE_MARKER, m);
    write_marker(CFG_END_MARKER, e);
    cfg_ch.valid <= 1'b0;
    mk_begin  = b;
    mk_middle = m;
    mk_end    = e;
  endtask

  // Mostly well-formed messages with random content; the rest is noise:
  // random headers, one-byte writes and orphan middle or end writes.
  task automatic run_random(input int unsigned quota);
    int unsigned stop_at;
    int unsigned pick;
    logic [ByteW-1:0] any_marker;
    stop_at = items_sent + quota;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      case ($urandom_range(2))
        0:       any_marker = mk_begin;
        1:       any_marker = mk_middle;
        default: any_marker = mk_end;
      endcase
      if (pick < 3) send_message(2, 40);
      else if (pick < 75) send_message($urandom_range(5, 2), 6);
      else if (pick < 85) send_write(ByteW'($urandom_range(255)), $urandom_range(3));
      else if (pick < 92) send_write(any_marker, 0);
      else send_write($urandom_range(1) ? mk_middle : mk_end, $urandom_range(4, 1));
      if ($urandom_range(39) == 0) drain_results();
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.rx_byte    <= '0;
    in_ch.write_done <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= CFG_BEGIN_MARKER;
    cfg_ch.data      <= '0;
    mk_begin  = BeginMarkerRst;
    mk_middle = MiddleMarkerRst;
    mk_end    = EndMarkerRst;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedSeq[i]) send_byte(DirectedSeq[i][7:0], DirectedSeq[i][8]);

    // Fill the store exactly, then overflow it by one byte.
    send_write(mk_begin, 32);
    send_write(mk_end, 32);
    send_write(mk_begin, 40);
    send_write(mk_middle, 20);
    send_write(mk_end, 5);
    run_random(40);

    // Extreme marker values, with neither side idling.
    change_markers(8'hFF, 8'h00, 8'h80);
    no_idle <= 1'b1;
    run_random(50);
    no_idle <= 1'b0;

    // Begin and end share a value: every begin write also closes the message.
    change_markers(8'hA5, 8'h5A, 8'hA5);
    run_random(50);

    // All three markers equal.
    change_markers(8'h00, 8'h00, 8'h00);
    run_random(40);

    change_markers(ByteW'($urandom_range(255)), ByteW'($urandom_range(255)),
                   ByteW'($urandom_range(255)));
    run_random(50);

    drain_results();
    repeat (TailCycles) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/msr_pkg.sv
hdl/msr_if.sv
hdl/msr_store.sv
hdl/marker_segment_reassembler_core.sv
bench/msr_reassembly_checker.sv
bench/tb_marker_segment_reassembler_core.sv
